// File: rtl/tsdf_pkg.sv
// Shared constants for the TURN-over-TCP stream deframer.
// Used by turn_tcp_stream_deframer and its port checker; no dependencies.
package tsdf_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned ModeW = 2;
  localparam int unsigned KindW = 2;
  localparam int unsigned LenW  = 16;
  localparam int unsigned RemW  = 17;

  // framing_mode register codes (anything else is unsupported)
  localparam logic [ModeW-1:0] ModeStandard = 2'd0;
  localparam logic [ModeW-1:0] ModePrefix   = 2'd1;

  // message_kind codes
  localparam logic [KindW-1:0] KindStun = 2'd0;
  localparam logic [KindW-1:0] KindChan = 2'd1;
  localparam logic [KindW-1:0] KindAlt  = 2'd2;

  // standard header position codes
  localparam logic [1:0] HdrPos0 = 2'd0;
  localparam logic [1:0] HdrPos1 = 2'd1;
  localparam logic [1:0] HdrPos2 = 2'd2;
  localparam logic [1:0] HdrPos3 = 2'd3;

  localparam logic [LenW-1:0] StunLimit    = 16'h4000;
  localparam int unsigned     StunHdrExtra = 20;
  localparam int unsigned     ChanHdrExtra = 4;
  localparam int unsigned     StdHeaderLen = 4;

  // body bytes after the header beyond the padded length field
  localparam logic [RemW-1:0] StunBodyExtra = RemW'(StunHdrExtra - StdHeaderLen);
  localparam logic [RemW-1:0] ChanBodyExtra = RemW'(ChanHdrExtra - StdHeaderLen);

endpackage

// File: rtl/turn_tcp_stream_deframer.sv
// TURN-over-TCP stream deframer, top level.
// Depends on tsdf_pkg.
//
// Splits a byte stream into TURN messages. One stream byte per input transfer; every byte that
// yields a result appears in the output register in the cycle after its transfer, with the
// final byte of a message flagged. The block takes one byte per clock unless the output stalls:
// the framing state (header position, length high byte, remaining count, kind) is updated by a
// single pass of logic in the accepting cycle, and the result sits in one output register. A new
// byte is taken whenever that register is empty or is being drained in the same cycle, so with
// the output side always ready the sustained rate is one byte per cycle; a stalled output holds
// the input off. Standard mode (framing_mode 0) reads a 4-byte header (STUN when the first 16
// bits are below 0x4000, else ChannelData), passes header, body and pad bytes on, and expects
// the total padded to a multiple of 4. Prefix mode (1) strips a 2-byte big-endian length, adds
// no pad, and reports a zero length as one empty-message result; prefix bytes give no other
// result. Other modes answer each byte with mode_error set and all other fields zero. A write to
// framing_mode restarts the deframer at a message boundary; write it only while idle.
module turn_tcp_stream_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tsdf_pkg::ModeW-1:0]    framing_mode_i,
  // stream input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tsdf_pkg::ByteW-1:0]    stream_byte_i,
  // message output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tsdf_pkg::ByteW-1:0]    message_byte_o,
  output logic                          last_of_message_o,
  output logic [tsdf_pkg::KindW-1:0]    message_kind_o,
  output logic                          empty_message_o,
  output logic                          mode_error_o
);
  import tsdf_pkg::*;

  // framing state
  logic [ModeW-1:0] mode_q;
  logic [1:0]       hdr_cnt_q, hdr_cnt_d;
  logic [ByteW-1:0] len_hi_q, len_hi_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [KindW-1:0] kind_q, kind_d;

  // result of the byte being accepted
  logic             res_valid;
  logic [ByteW-1:0] res_byte;
  logic             res_last;
  logic [KindW-1:0] res_kind;
  logic             res_empty;
  logic             res_err;

  // output register
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_last_q;
  logic [KindW-1:0] out_kind_q;
  logic             out_empty_q;
  logic             out_err_q;

  logic             in_xfer;
  logic             cfg_xfer;
  logic [LenW-1:0]  len_field;
  logic [RemW-1:0]  len_padded;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;

  // output register frees up when empty or draining this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign len_field  = {len_hi_q, stream_byte_i};
  // round the 16-bit length up to a multiple of 4, in 17 bits
  assign len_padded = ({1'b0, len_field} + RemW'(3)) & ~RemW'(3);

  always_comb begin
    hdr_cnt_d = hdr_cnt_q;
    len_hi_d  = len_hi_q;
    rem_d     = rem_q;
    kind_d    = kind_q;
    res_valid = 1'b0;
    res_byte  = '0;
    res_last  = 1'b0;
    res_kind  = KindStun;
    res_empty = 1'b0;
    res_err   = 1'b0;

    if (mode_q != ModeStandard && mode_q != ModePrefix) begin
      // unsupported mode: discard byte, hold state
      res_valid = 1'b1;
      res_err   = 1'b1;
    end else if (rem_q != '0) begin
      // body or pad byte
      rem_d     = rem_q - RemW'(1);
      res_valid = 1'b1;
      res_byte  = stream_byte_i;
      res_last  = (rem_q == RemW'(1));
      res_kind  = kind_q;
    end else if (mode_q == ModeStandard) begin
      res_valid = 1'b1;
      res_byte  = stream_byte_i;
      res_kind  = kind_q;
      unique case (hdr_cnt_q)
        HdrPos0: begin
          kind_d    = ({stream_byte_i, 8'h00} < StunLimit) ? KindStun : KindChan;
          res_kind  = kind_d;
          hdr_cnt_d = HdrPos1;
        end
        HdrPos1: begin
          hdr_cnt_d = HdrPos2;
        end
        HdrPos2: begin
          len_hi_d  = stream_byte_i;
          hdr_cnt_d = HdrPos3;
        end
        HdrPos3: begin
          rem_d     = len_padded + ((kind_q == KindStun) ? StunBodyExtra : ChanBodyExtra);
          hdr_cnt_d = HdrPos0;
          res_last  = (rem_d == '0);
        end
        default: begin
          hdr_cnt_d = HdrPos0;
        end
      endcase
    end else begin
      // prefix mode: length bytes are stripped
      kind_d = KindAlt;
      if (hdr_cnt_q == HdrPos0) begin
        len_hi_d  = stream_byte_i;
        hdr_cnt_d = HdrPos1;
      end else begin
        hdr_cnt_d = HdrPos0;
        rem_d     = {1'b0, len_field};
        if (len_field == '0) begin
          res_valid = 1'b1;
          res_last  = 1'b1;
          res_kind  = KindAlt;
          res_empty = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeStandard;
      hdr_cnt_q <= HdrPos0;
      len_hi_q  <= '0;
      rem_q     <= '0;
      kind_q    <= KindStun;
    end else if (cfg_xfer) begin
      mode_q    <= framing_mode_i;
      hdr_cnt_q <= HdrPos0;
      rem_q     <= '0;
    end else if (in_xfer) begin
      hdr_cnt_q <= hdr_cnt_d;
      len_hi_q  <= len_hi_d;
      rem_q     <= rem_d;
      kind_q    <= kind_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_byte_q  <= res_byte;
      out_last_q  <= res_last;
      out_kind_q  <= res_kind;
      out_empty_q <= res_empty;
      out_err_q   <= res_err;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign message_byte_o    = out_byte_q;
  assign last_of_message_o = out_last_q;
  assign message_kind_o    = out_kind_q;
  assign empty_message_o   = out_empty_q;
  assign mode_error_o      = out_err_q;

endmodule

// File: rtl/tsdf_checker.sv
// Port-level checker for turn_tcp_stream_deframer, with its bind.
// Depends on tsdf_pkg.
module tsdf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [tsdf_pkg::ByteW-1:0] message_byte_o,
  input logic                       last_of_message_o,
  input logic [tsdf_pkg::KindW-1:0] message_kind_o,
  input logic                       empty_message_o,
  input logic                       mode_error_o
);
  import tsdf_pkg::*;

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transfer dropped while stalled");

  // stalled output must block input, or the result register is overwritten
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_error_o |->
      message_byte_o == '0 && !last_of_message_o && message_kind_o == KindStun &&
      !empty_message_o)
    else $error("mode error result carries data");

  a_empty_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_message_o |->
      last_of_message_o && message_kind_o == KindAlt && message_byte_o == '0 &&
      !mode_error_o)
    else $error("malformed empty-message result");

endmodule

bind turn_tcp_stream_deframer tsdf_checker u_tsdf_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .message_byte_o    (message_byte_o),
  .last_of_message_o (last_of_message_o),
  .message_kind_o    (message_kind_o),
  .empty_message_o   (empty_message_o),
  .mode_error_o      (mode_error_o)
);
